>>> design/cnv3_pkg.sv
// ----------------------------------------------------------------------------
// cnv3_pkg
// Shared constants, types and register indexes for the 3x3 pixel filter.
// ----------------------------------------------------------------------------
`default_nettype none

package cnv3_pkg;

    localparam int MAX_WIDTH      = 2048;
    localparam int COEF_FRAC_BITS = 8;
    localparam int KERNEL_SIZE    = 3;
    localparam int TAPS           = KERNEL_SIZE * KERNEL_SIZE;

    localparam int SAMPLE_W   = 8;
    localparam int NUM_CHAN   = 3;
    localparam int PIX_W      = SAMPLE_W * NUM_CHAN;
    localparam int COEF_W     = 16;
    localparam int KROW_W     = COEF_W * KERNEL_SIZE;
    localparam int PROD_W     = COEF_W + SAMPLE_W;
    localparam int SUM_W      = PROD_W + 4;

    localparam int WIDTH_REG_W = 12;
    localparam int HEIGHT_W    = 13;
    localparam int CNT_W       = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = KROW_W;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int WEFF_W = $clog2(MAX_WIDTH + 1);
    localparam int LAG_W  = $clog2(MAX_WIDTH + 2);
    localparam int ROW_W  = HEIGHT_W;
    localparam int LINE_W = 2 * PIX_W;

    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 8'd255;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH    = 3'd0,
        CFG_HEIGHT   = 3'd1,
        CFG_CHANNELS = 3'd2,
        CFG_K_TOP    = 3'd3,
        CFG_K_MID    = 3'd4,
        CFG_K_BOT    = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic [WIDTH_REG_W-1:0] width;
        logic [HEIGHT_W-1:0]    height;
        logic [CNT_W-1:0]       chan_count;
        logic [KROW_W-1:0]      k_top;
        logic [KROW_W-1:0]      k_mid;
        logic [KROW_W-1:0]      k_bot;
    } cfg_t;

    // per-beat control that travels from the counters into the window stage
    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic [COL_W-1:0] x;
        logic             x_zero;
        logic             produce;
        logic [TAPS-1:0]  ok;
        logic             last;
    } meta_t;

    typedef logic [TAPS-1:0][PIX_W-1:0] win_t;
    typedef logic [NUM_CHAN-1:0][SAMPLE_W-1:0] pixel_t;

endpackage

`default_nettype wire

>>> design/cnv3_ctrl.sv
// ----------------------------------------------------------------------------
// cnv3_ctrl
// Raster position counters, fill lag and border mask for each input beat.
// ----------------------------------------------------------------------------
`default_nettype none

module cnv3_ctrl
    import cnv3_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire cfg_t             cfg,
    input  wire logic             in_fire,
    input  wire logic             op,
    input  wire logic [PIX_W-1:0] pix_in,
    output meta_t                 meta
);

    logic [COL_W-1:0] in_col_reg, in_col_next;
    logic [COL_W-1:0] out_col_reg, out_col_next;
    logic [ROW_W-1:0] out_row_reg, out_row_next;
    logic [LAG_W-1:0] lag_reg, lag_next;

    logic [WEFF_W-1:0]   w;
    logic [HEIGHT_W-1:0] h;
    logic [COL_W-1:0]    x;
    logic                col_end;
    logic                row_end;

    always_comb
    begin
        if (cfg.width == '0)
            w = WEFF_W'(1);
        else if (32'(cfg.width) > MAX_WIDTH)
            w = WEFF_W'(MAX_WIDTH);
        else
            w = WEFF_W'(cfg.width);
        h = (cfg.height == '0) ? HEIGHT_W'(1) : cfg.height;
    end

    always_comb
    begin
        x = (32'(in_col_reg) < 32'(w)) ? in_col_reg : '0;

        meta.pix     = op ? '0 : pix_in;
        meta.x       = x;
        meta.x_zero  = (x == '0);
        meta.produce = 32'(lag_reg) >= 32'(w) + 32'd1;

        // neighbor rows -1/0/+1 and columns -1/0/+1 of the output pixel
        for (int r = 0; r < KERNEL_SIZE; r++)
        begin
            for (int c = 0; c < KERNEL_SIZE; c++)
            begin
                meta.ok[r*KERNEL_SIZE + c] =
                    (32'(out_row_reg) + 32'(r) >= 32'd1) &&
                    (32'(out_row_reg) + 32'(r) < 32'(h) + 32'd1) &&
                    (32'(out_col_reg) + 32'(c) >= 32'd1) &&
                    (32'(out_col_reg) + 32'(c) < 32'(w) + 32'd1);
            end
        end

        col_end   = 32'(out_col_reg) + 32'd1 >= 32'(w);
        row_end   = 32'(out_row_reg) + 32'd1 >= 32'(h);
        meta.last = meta.produce && col_end && row_end;

        in_col_next  = (32'(x) + 32'd1 >= 32'(w)) ? '0 : COL_W'(32'(x) + 32'd1);
        lag_next     = lag_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;

        if (!meta.produce)
            lag_next = LAG_W'(32'(lag_reg) + 32'd1);
        else if (meta.last)
        begin
            in_col_next  = '0;
            lag_next     = '0;
            out_col_next = '0;
            out_row_next = '0;
        end
        else if (col_end)
        begin
            out_col_next = '0;
            out_row_next = ROW_W'(32'(out_row_reg) + 32'd1);
        end
        else
            out_col_next = COL_W'(32'(out_col_reg) + 32'd1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            lag_reg     <= '0;
        end
        else if (in_fire)
        begin
            in_col_reg  <= in_col_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            lag_reg     <= lag_next;
        end
    end

    // frame end returns every counter to zero
    a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && meta.last |=>
            (lag_reg == '0) && (in_col_reg == '0) &&
            (out_col_reg == '0) && (out_row_reg == '0))
        else $error("counters not cleared after frame end");

    // fill beats advance the lag and the input column, not the output counters
    a_fill_lag: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && !meta.produce |=> lag_reg == $past(lag_reg) + LAG_W'(1))
        else $error("lag count did not advance on a fill beat");

endmodule

`default_nettype wire

>>> design/cnv3_window.sv
// ----------------------------------------------------------------------------
// cnv3_window
// Two line stores (one wide memory) and the 3x3 window, with masked taps.
// ----------------------------------------------------------------------------
`default_nettype none

module cnv3_window
    import cnv3_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             rd_en,
    input  wire logic [COL_W-1:0] rd_addr,
    input  wire logic             s1_fire,
    input  wire meta_t            s1,
    output win_t                  win
);

    // entry = {older row, newer row}
    logic [LINE_W-1:0] line_mem [MAX_WIDTH];
    logic [LINE_W-1:0] rd_data_reg;
    logic              fwd_reg;
    logic [LINE_W-1:0] fwd_data_reg;

    logic [KERNEL_SIZE-1:0][KERNEL_SIZE-1:0][PIX_W-1:0] win_reg;

    logic [LINE_W-1:0] line_eff;
    logic [PIX_W-1:0]  top;
    logic [PIX_W-1:0]  mid;
    logic [LINE_W-1:0] wr_data;
    logic [KERNEL_SIZE-1:0][PIX_W-1:0] new_col;

    always_comb
    begin
        line_eff = fwd_reg ? fwd_data_reg : rd_data_reg;
        top      = line_eff[LINE_W-1:PIX_W];
        mid      = line_eff[PIX_W-1:0];
        wr_data  = {mid, s1.pix};
        new_col  = {s1.pix, mid, top};

        // at column zero the right-hand column lies past the previous row end
        for (int r = 0; r < KERNEL_SIZE; r++)
        begin
            win[r*KERNEL_SIZE + 0] = s1.ok[r*KERNEL_SIZE + 0] ? win_reg[r][1] : '0;
            win[r*KERNEL_SIZE + 1] = s1.ok[r*KERNEL_SIZE + 1] ? win_reg[r][2] : '0;
            win[r*KERNEL_SIZE + 2] = (s1.ok[r*KERNEL_SIZE + 2] && !s1.x_zero) ?
                                     new_col[r] : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= line_mem[rd_addr];
        if (s1_fire)
            line_mem[s1.x] <= wr_data;
    end

    // read in the same cycle as the write to that entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg      <= 1'b0;
            fwd_data_reg <= '0;
        end
        else if (rd_en)
        begin
            fwd_reg      <= s1_fire && (rd_addr == s1.x);
            fwd_data_reg <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            win_reg <= '0;
        else if (s1_fire)
        begin
            for (int r = 0; r < KERNEL_SIZE; r++)
            begin
                win_reg[r][0] <= win_reg[r][1];
                win_reg[r][1] <= win_reg[r][2];
                win_reg[r][2] <= new_col[r];
            end
        end
    end

endmodule

`default_nettype wire

>>> design/cnv3_mac.sv
// ----------------------------------------------------------------------------
// cnv3_mac
// Registered tap products, then per-channel sum, floor and clamp.
// ----------------------------------------------------------------------------
`default_nettype none

module cnv3_mac
    import cnv3_pkg::*;
(
    input  wire logic clk,
    input  wire logic load,
    input  wire cfg_t cfg,
    input  wire win_t win,
    output pixel_t    result
);

    logic signed [PROD_W-1:0] prod_reg [NUM_CHAN][TAPS];
    logic [TAPS-1:0][COEF_W-1:0] coef;
    logic signed [SUM_W-1:0] acc [NUM_CHAN];
    logic signed [SUM_W-1:0] shifted [NUM_CHAN];

    always_comb
    begin
        for (int c = 0; c < KERNEL_SIZE; c++)
        begin
            coef[c]                 = cfg.k_top[c*COEF_W +: COEF_W];
            coef[KERNEL_SIZE + c]   = cfg.k_mid[c*COEF_W +: COEF_W];
            coef[2*KERNEL_SIZE + c] = cfg.k_bot[c*COEF_W +: COEF_W];
        end
    end

    // both operands widened to the product width before the multiply
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int ch = 0; ch < NUM_CHAN; ch++)
                for (int t = 0; t < TAPS; t++)
                    prod_reg[ch][t] <= PROD_W'($signed(coef[t])) *
                        PROD_W'($signed({1'b0, win[t][ch*SAMPLE_W +: SAMPLE_W]}));
        end
    end

    always_comb
    begin
        for (int ch = 0; ch < NUM_CHAN; ch++)
        begin
            acc[ch] = '0;
            for (int t = 0; t < TAPS; t++)
                acc[ch] = acc[ch] + SUM_W'(prod_reg[ch][t]);
            shifted[ch] = acc[ch] >>> COEF_FRAC_BITS;
            if (acc[ch] < 0)
                result[ch] = '0;
            else if (shifted[ch] > SUM_W'(SAMPLE_MAX))
                result[ch] = SAMPLE_MAX;
            else
                result[ch] = shifted[ch][SAMPLE_W-1:0];
        end
    end

endmodule

`default_nettype wire

>>> design/conv3x3_rgb_zero_pad_clamp.sv
// ----------------------------------------------------------------------------
// conv3x3_rgb_zero_pad_clamp
// 3x3 zero-padded convolution over a raster RGB stream, clamped to 0..255.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats (in_valid/in_ready) carry op plus three 8-bit samples, one
//   pixel per beat in raster order. op = 1 is a flush tick (black pixel).
//   Output beats (out_valid/out_ready) carry the filtered pixel, alpha and
//   frame_last. Output pixel k comes from input beat k + frame_width + 1;
//   the first frame_width + 1 beats of a frame give no output, so after the
//   last pixel send frame_width + 1 flush ticks to drain the frame.
//   Throughput: one beat per cycle unless a stalled receiver holds the stages.
//   The edge that accepts a beat loads the window/line-store stage; the beat
//   then goes through the tap stage, product stage, and sum/clamp into the
//   output register, where out_valid rises; the registered read port of the
//   line store sets the window stage.
//   Configuration (cfg_wr_en/cfg_index/cfg_data) is written while idle.
//   Reset clears counters, window and all stage valids; line stores are not
//   cleared and need no clearing pass (unwritten entries are always masked).
//   When the receiver stalls, results back up through the stages; input is
//   still taken while any stage holds a bubble.
// ----------------------------------------------------------------------------
`default_nettype none

module conv3x3_rgb_zero_pad_clamp
    import cnv3_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,

    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic                  op,
    input  wire logic [SAMPLE_W-1:0]   chan0_in,
    input  wire logic [SAMPLE_W-1:0]   chan1_in,
    input  wire logic [SAMPLE_W-1:0]   chan2_in,

    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [SAMPLE_W-1:0]        chan0_out,
    output logic [SAMPLE_W-1:0]        chan1_out,
    output logic [SAMPLE_W-1:0]        chan2_out,
    output logic [SAMPLE_W-1:0]        alpha_out,
    output logic                       frame_last
);

    cfg_t cfg_reg;

    // stage valids: s1 window, s2 taps, s3 products, output register
    logic  s1_valid_reg, s2_valid_reg, s3_valid_reg, out_valid_reg;
    meta_t s1_reg;
    win_t  s2_win_reg;
    logic  s2_last_reg, s3_last_reg;

    meta_t  meta;
    win_t   win;
    pixel_t mac_result;

    logic in_fire, s1_fire, s1_rdy, s2_rdy, s3_rdy, out_rdy;
    logic [CNT_W-1:0] nch;

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.width      <= WIDTH_REG_W'(1);
            cfg_reg.height     <= HEIGHT_W'(1);
            cfg_reg.chan_count <= CNT_W'(3);
            cfg_reg.k_top      <= '0;
            cfg_reg.k_mid      <= '0;
            cfg_reg.k_bot      <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_WIDTH:    cfg_reg.width      <= cfg_data[WIDTH_REG_W-1:0];
                CFG_HEIGHT:   cfg_reg.height     <= cfg_data[HEIGHT_W-1:0];
                CFG_CHANNELS: cfg_reg.chan_count <= cfg_data[CNT_W-1:0];
                CFG_K_TOP:    cfg_reg.k_top      <= cfg_data[KROW_W-1:0];
                CFG_K_MID:    cfg_reg.k_mid      <= cfg_data[KROW_W-1:0];
                CFG_K_BOT:    cfg_reg.k_bot      <= cfg_data[KROW_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- handshake chain ----------------
    // a beat that gives no output retires from s1 without needing s2
    always_comb
    begin
        out_rdy  = !out_valid_reg || out_ready;
        s3_rdy   = !s3_valid_reg || out_rdy;
        s2_rdy   = !s2_valid_reg || s3_rdy;
        s1_rdy   = !s1_valid_reg || !s1_reg.produce || s2_rdy;
        s1_fire  = s1_valid_reg && s1_rdy;
        in_ready = s1_rdy;
        in_fire  = in_valid && in_ready;
    end

    // ---------------- counters and border mask ----------------
    cnv3_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .in_fire (in_fire),
        .op      (op),
        .pix_in  ({chan2_in, chan1_in, chan0_in}),
        .meta    (meta)
    );

    // ---------------- line stores and window ----------------
    cnv3_window u_window (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (in_fire),
        .rd_addr (meta.x),
        .s1_fire (s1_fire),
        .s1      (s1_reg),
        .win     (win)
    );

    // ---------------- products, sum and clamp ----------------
    cnv3_mac u_mac (
        .clk    (clk),
        .load   (s2_valid_reg && s3_rdy),
        .cfg    (cfg_reg),
        .win    (s2_win_reg),
        .result (mac_result)
    );

    always_comb
    begin
        if (cfg_reg.chan_count == '0)
            nch = CNT_W'(1);
        else if (cfg_reg.chan_count > CNT_W'(4))
            nch = CNT_W'(4);
        else
            nch = cfg_reg.chan_count;
    end

    // ---------------- stage valids ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
                s1_valid_reg <= 1'b1;
            else if (s1_fire)
                s1_valid_reg <= 1'b0;
            if (s2_rdy)
                s2_valid_reg <= s1_fire && s1_reg.produce;
            if (s3_rdy)
                s3_valid_reg <= s2_valid_reg;
            if (out_rdy)
                out_valid_reg <= s3_valid_reg;
        end
    end

    // ---------------- stage payload ----------------
    always_ff @(posedge clk)
    begin
        if (in_fire)
            s1_reg <= meta;
        if (s1_fire && s1_reg.produce)
        begin
            s2_win_reg  <= win;
            s2_last_reg <= s1_reg.last;
        end
        if (s2_valid_reg && s3_rdy)
            s3_last_reg <= s2_last_reg;
        if (s3_valid_reg && out_rdy)
        begin
            chan0_out  <= mac_result[0];
            chan1_out  <= (nch >= CNT_W'(2)) ? mac_result[1] : '0;
            chan2_out  <= (nch >= CNT_W'(3)) ? mac_result[2] : '0;
            alpha_out  <= (nch == CNT_W'(4)) ? SAMPLE_MAX : '0;
            frame_last <= s3_last_reg;
        end
    end

    assign out_valid = out_valid_reg;

    // an output-producing beat always finds room in the tap stage
    a_s2_load: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && s1_reg.produce |=> s2_valid_reg)
        else $error("producing beat lost between window and tap stage");

    // a new beat is only taken when the window stage is free to move
    a_in_order: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |-> (!s1_valid_reg || s1_fire))
        else $error("input beat accepted over a held window stage");

endmodule

`default_nettype wire

>>> verif/conv3x3_rgb_zero_pad_clamp_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// conv3x3_rgb_zero_pad_clamp_test
// Self-checking bench for the 3x3 zero-padded, clamped pixel filter.
// ----------------------------------------------------------------------------
// A cycle-free predictor mirrors the line stores, the window and the frame
// counters. Every accepted input beat is run through it, and each output
// pixel it yields is queued. The checker compares every output beat, field
// by field, against the oldest queued pixel. Stimulus runs through the reset
// state, directed corner frames, all channel counts, zero width and height,
// receiver hold-off, a sender pause, and random frames with noise.
// Both sides idle at random per beat.
// ----------------------------------------------------------------------------

module conv3x3_rgb_zero_pad_clamp_test;

    import cnv3_pkg::*;

    // op codes of an input beat
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    localparam int IDLE_PAD     = 8;        // cycles after the last result, > latency
    localparam int RANDOM_BEATS = 1000;

    typedef struct packed {
        logic [SAMPLE_W-1:0] chan0;
        logic [SAMPLE_W-1:0] chan1;
        logic [SAMPLE_W-1:0] chan2;
        logic [SAMPLE_W-1:0] alpha;
        logic                last;
    } pix_result_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic                  op;
    logic [SAMPLE_W-1:0]   chan0_in;
    logic [SAMPLE_W-1:0]   chan1_in;
    logic [SAMPLE_W-1:0]   chan2_in;
    logic                  out_valid;
    logic                  out_ready;
    logic [SAMPLE_W-1:0]   chan0_out;
    logic [SAMPLE_W-1:0]   chan1_out;
    logic [SAMPLE_W-1:0]   chan2_out;
    logic [SAMPLE_W-1:0]   alpha_out;
    logic                  frame_last;

    conv3x3_rgb_zero_pad_clamp i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .op         (op),
        .chan0_in   (chan0_in),
        .chan1_in   (chan1_in),
        .chan2_in   (chan2_in),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .chan0_out  (chan0_out),
        .chan1_out  (chan1_out),
        .chan2_out  (chan2_out),
        .alpha_out  (alpha_out),
        .frame_last (frame_last)
    );

    // ------------------------------------------------------------------
    // Predictor state: register shadow, line stores, window, counters
    // ------------------------------------------------------------------
    cfg_t             cfg_shadow;
    logic [PIX_W-1:0] line_older [MAX_WIDTH];
    logic [PIX_W-1:0] line_newer [MAX_WIDTH];
    win_t             window_q;
    int unsigned      col_in;
    int unsigned      col_out;
    int unsigned      row_out;
    int unsigned      fill_cnt;     // beats into the frame before output starts

    pix_result_t      pending_pixels [$];

    // run bookkeeping
    int  err_count;
    int  beats_sent;
    int  random_beats;
    int  pixels_checked;
    int  frames_seen;
    int  settings_done;
    bit  idle_on;       // random gaps on both sides
    int  hold_req;      // long receiver hold-off, picked up by the ready process

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor helpers
    // ------------------------------------------------------------------
    function automatic int unsigned eff_width();
        if (cfg_shadow.width == 0)
            return 1;
        if (cfg_shadow.width > MAX_WIDTH)
            return MAX_WIDTH;
        return 32'(cfg_shadow.width);
    endfunction

    function automatic int unsigned eff_height();
        return (cfg_shadow.height == 0) ? 1 : 32'(cfg_shadow.height);
    endfunction

    function automatic int unsigned eff_chans();
        if (cfg_shadow.chan_count == 0)
            return 1;
        return (cfg_shadow.chan_count > CNT_W'(4)) ? 4 : 32'(cfg_shadow.chan_count);
    endfunction

    // tap 0 is upper-left, tap 8 lower-right (correlation, not convolution)
    function automatic logic signed [COEF_W-1:0] coef_at_tap(input int tap);
        logic [KROW_W-1:0] row_bits;
        case (tap / KERNEL_SIZE)
            0:       row_bits = cfg_shadow.k_top;
            1:       row_bits = cfg_shadow.k_mid;
            default: row_bits = cfg_shadow.k_bot;
        endcase
        return $signed(row_bits[(tap % KERNEL_SIZE) * COEF_W +: COEF_W]);
    endfunction

    function automatic void model_reset();
        cfg_shadow            = '0;
        cfg_shadow.width      = WIDTH_REG_W'(1);
        cfg_shadow.height     = HEIGHT_W'(1);
        cfg_shadow.chan_count = CNT_W'(3);
        foreach (line_older[i])
        begin
            line_older[i] = '0;
            line_newer[i] = '0;
        end
        window_q = '0;
        col_in   = 0;
        col_out  = 0;
        row_out  = 0;
        fill_cnt = 0;
    endfunction

    // One accepted beat: shift the window, update the line stores and
    // counters, and return 1 with the filtered pixel once the fill is over.
    function automatic bit predict_pixel(input logic op_code,
                                         input logic [SAMPLE_W-1:0] s0, s1, s2,
                                         output pix_result_t res);
        int unsigned         w, h, nch, x;
        int                  nr, nc;
        logic [PIX_W-1:0]    pix, top, mid;
        win_t                prev, win;
        bit [TAPS-1:0]       ok;
        longint              acc;
        logic [SAMPLE_W-1:0] val [NUM_CHAN];

        w   = eff_width();
        h   = eff_height();
        nch = eff_chans();
        x   = (col_in < w) ? col_in : 0;
        // a flush tick is a black pixel, payload ignored
        pix = (op_code == OP_FLUSH) ? '0 : {s2, s1, s0};
        top = line_older[x];
        mid = line_newer[x];

        prev = window_q;
        for (int r = 0; r < KERNEL_SIZE; r++)
        begin
            window_q[r*3]   = window_q[r*3+1];
            window_q[r*3+1] = window_q[r*3+2];
        end
        window_q[2]   = top;
        window_q[5]   = mid;
        window_q[8]   = pix;
        line_older[x] = mid;
        line_newer[x] = pix;
        col_in        = (x + 1 >= w) ? 0 : x + 1;

        res = '0;
        if (fill_cnt < w + 1)
        begin
            fill_cnt++;
            return 1'b0;
        end

        // column 0: the new column belongs to the next row, use the old window
        if (x != 0)
            win = window_q;
        else
        begin
            win = '0;
            for (int r = 0; r < KERNEL_SIZE; r++)
            begin
                win[r*3]   = prev[r*3+1];
                win[r*3+1] = prev[r*3+2];
            end
        end

        // zero padding: neighbors outside the frame drop out of the sum
        for (int r = 0; r < KERNEL_SIZE; r++)
            for (int c = 0; c < KERNEL_SIZE; c++)
            begin
                nr = int'(row_out) + r - 1;
                nc = int'(col_out) + c - 1;
                ok[r*3+c] = nr >= 0 && nr < int'(h) && nc >= 0 && nc < int'(w);
            end

        for (int ch = 0; ch < NUM_CHAN; ch++)
        begin
            acc = 0;
            for (int i = 0; i < TAPS; i++)
                if (ok[i])
                    acc += longint'(coef_at_tap(i)) *
                           longint'(win[i][ch*SAMPLE_W +: SAMPLE_W]);
            if (ch >= nch || acc < 0)
                val[ch] = '0;
            else if ((acc >>> COEF_FRAC_BITS) > 255)
                val[ch] = SAMPLE_MAX;
            else
                val[ch] = acc[COEF_FRAC_BITS +: SAMPLE_W];
        end

        res.chan0 = val[0];
        res.chan1 = val[1];
        res.chan2 = val[2];
        res.alpha = (nch == 4) ? SAMPLE_MAX : '0;
        res.last  = (row_out + 1 >= h) && (col_out + 1 >= w);

        if (res.last)
        begin
            col_in   = 0;
            col_out  = 0;
            row_out  = 0;
            fill_cnt = 0;
        end
        else if (col_out + 1 >= w)
        begin
            col_out = 0;
            row_out++;
        end
        else
            col_out++;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Random value helpers
    // ------------------------------------------------------------------
    function automatic logic [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return SAMPLE_MAX;
            default: return SAMPLE_W'($urandom_range(0, 255));
        endcase
    endfunction

    // mostly small coefficients so that sums land inside 0..255 often
    function automatic logic [COEF_W-1:0] rand_coef();
        int v;
        case ($urandom_range(0, 7))
            0:       return COEF_W'($urandom_range(0, 65535));
            1:       return 16'h0100;
            default:
            begin
                v = int'($urandom_range(0, 640)) - 320;
                return v[COEF_W-1:0];
            end
        endcase
    endfunction

    function automatic logic [KROW_W-1:0] rand_krow();
        return {rand_coef(), rand_coef(), rand_coef()};
    endfunction

    // left coefficient in the low bits
    function automatic logic [KROW_W-1:0] krow(input logic [COEF_W-1:0] left, ctr, right);
        return {right, ctr, left};
    endfunction

    function automatic int unsigned pick_width();
        case ($urandom_range(0, 19))
            0:       return 0;
            1, 2:    return $urandom_range(13, 64);
            default: return $urandom_range(1, 12);
        endcase
    endfunction

    function automatic int unsigned pick_height();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return $urandom_range(7, 10);
            default: return $urandom_range(1, 6);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Offer one beat and return at the edge where it is taken. Valid is left
    // high so back-to-back beats never lower and raise it in one step.
    task automatic send_beat(input logic op_code, input logic [SAMPLE_W-1:0] s0, s1, s2);
        int unsigned gap;
        pix_result_t res;
        gap = idle_on ? $urandom_range(0, 9) : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        op       <= op_code;
        chan0_in <= s0;
        chan1_in <= s1;
        chan2_in <= s2;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (predict_pixel(op_code, s0, s1, s2, res))
            pending_pixels.push_back(res);
        beats_sent++;
    endtask

    // stop offering and wait until every predicted pixel has come out
    task automatic wait_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_pixels.size() != 0);
    endtask

    task automatic wait_idle();
        wait_results();
        repeat (IDLE_PAD) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    // all six registers, only once the pipeline has gone quiet
    task automatic configure(input int unsigned w, h, ch,
                             input logic [KROW_W-1:0] kt, km, kb);
        wait_idle();
        write_reg(CFG_WIDTH, CFG_DATA_W'(w));
        write_reg(CFG_HEIGHT, CFG_DATA_W'(h));
        write_reg(CFG_CHANNELS, CFG_DATA_W'(ch));
        write_reg(CFG_K_TOP, kt);
        write_reg(CFG_K_MID, km);
        write_reg(CFG_K_BOT, kb);
        cfg_wr_en <= 1'b0;
        cfg_shadow.width      = w[WIDTH_REG_W-1:0];
        cfg_shadow.height     = h[HEIGHT_W-1:0];
        cfg_shadow.chan_count = ch[CNT_W-1:0];
        cfg_shadow.k_top      = kt;
        cfg_shadow.k_mid      = km;
        cfg_shadow.k_bot      = kb;
        settings_done++;
    endtask

    // One whole frame plus its drain. noise_pct turns pixels into flush
    // ticks (black), pixel_drain drains with pixels past the last row, and
    // pause_at holds the sender at that beat until all results are in.
    task automatic send_frame(input int unsigned noise_pct, input bit pixel_drain,
                              input int pause_at);
        int unsigned w, n;
        w = eff_width();
        n = w * eff_height();
        for (int i = 0; i < n; i++)
        begin
            if (i == pause_at)
                wait_results();
            if ($urandom_range(0, 99) < noise_pct)
                send_beat(OP_FLUSH, rand_sample(), rand_sample(), rand_sample());
            else
                send_beat(OP_PIXEL, rand_sample(), rand_sample(), rand_sample());
        end
        for (int i = 0; i <= int'(w); i++)
            send_beat(pixel_drain ? OP_PIXEL : OP_FLUSH,
                      rand_sample(), rand_sample(), rand_sample());
    endtask

    // flush ticks until the counters sit at the start of a frame
    task automatic finish_frame();
        while (fill_cnt != 0 || col_in != 0)
            send_beat(OP_FLUSH, '0, '0, '0);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // reset values: 1x1 frame, three channels, all-zero kernel
    task automatic test_reset_state();
        send_beat(OP_PIXEL, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX);
        send_beat(OP_FLUSH, '0, '0, '0);
        send_beat(OP_FLUSH, '0, '0, '0);
    endtask

    // Sample extremes through an identity kernel, a flush tick inside the
    // frame, drain partly by pixels past the last row; then extreme coefficients.
    task automatic test_corner_pixels();
        configure(3, 2, 4, krow(16'h0000, 16'h0000, 16'h0000),
                  krow(16'h0000, 16'h0100, 16'h0000), krow(16'h0000, 16'h0000, 16'h0000));
        send_beat(OP_PIXEL, 8'h00, 8'hFF, 8'h80);
        send_beat(OP_PIXEL, 8'hFF, 8'h00, 8'h7F);
        send_beat(OP_FLUSH, 8'hFF, 8'hFF, 8'hFF);   // black despite the payload
        send_beat(OP_PIXEL, 8'h01, 8'hFE, 8'h55);
        send_beat(OP_PIXEL, 8'hAA, 8'h55, 8'hFF);
        send_beat(OP_PIXEL, 8'hFF, 8'hFF, 8'hFF);
        send_beat(OP_PIXEL, 8'hFF, 8'hFF, 8'hFF);   // past the frame: masked
        send_beat(OP_PIXEL, 8'hFF, 8'hFF, 8'hFF);
        send_beat(OP_FLUSH, '0, '0, '0);
        send_beat(OP_FLUSH, '0, '0, '0);
        // large positive top, mixed middle, most negative bottom: both clamps
        configure(3, 2, 4, krow(16'h7FFF, 16'h7FFF, 16'h7FFF),
                  krow(16'h8000, 16'h0080, 16'h7FFF), krow(16'h8000, 16'h8000, 16'h8000));
        send_frame(0, 1'b0, -1);
    endtask

    // channel counts 0 (acts as 1) through 4, and 7 (acts as 4)
    task automatic test_channel_counts();
        int unsigned chan_list [6] = '{0, 1, 2, 3, 4, 7};
        foreach (chan_list[i])
        begin
            configure(4, 3, chan_list[i], rand_krow(), rand_krow(), rand_krow());
            send_frame(5, 1'b0, -1);
        end
    endtask

    // zero width and height act as 1; a tall one-pixel-wide frame at full rate
    task automatic test_geometry_limits();
        configure(0, 3, 3, rand_krow(), rand_krow(), rand_krow());
        send_frame(0, 1'b0, -1);
        configure(5, 0, 3, rand_krow(), rand_krow(), rand_krow());
        send_frame(0, 1'b1, -1);
        idle_on = 1'b0;
        configure(1, 40, 2, rand_krow(), rand_krow(), rand_krow());
        send_frame(2, 1'b0, -1);
        idle_on = 1'b1;
    endtask

    // Receiver holds off long enough for the stages to fill and in_ready to
    // drop; then the sender stops mid-frame until the pipeline has emptied.
    task automatic test_stalls();
        configure(16, 8, 3, rand_krow(), rand_krow(), rand_krow());
        idle_on  = 1'b0;
        hold_req = 400;
        send_frame(0, 1'b0, -1);
        idle_on = 1'b1;
        send_frame(0, 1'b0, 64);
    endtask

    // Random settings and frames. Mostly clean frames; some carry flush
    // ticks inside or drain with pixels, some are loose beats with random
    // op that ignore frame boundaries and get flushed out afterwards.
    task automatic test_random_traffic();
        int          start;
        int unsigned w, h, kind;
        start = beats_sent;
        while (beats_sent - start < RANDOM_BEATS)
        begin
            w = pick_width();
            h = (w > 12) ? $urandom_range(1, 3) : pick_height();
            configure(w, h, $urandom_range(0, 7), rand_krow(), rand_krow(), rand_krow());
            idle_on = ($urandom_range(0, 4) != 0);
            repeat ($urandom_range(1, 3))
            begin
                kind = $urandom_range(0, 9);
                if (kind < 7)
                    send_frame((kind < 2) ? 15 : 0, kind == 2, -1);
                else
                begin
                    repeat ($urandom_range(1, 40))
                        send_beat($urandom_range(0, 1) ? OP_FLUSH : OP_PIXEL,
                                  rand_sample(), rand_sample(), rand_sample());
                    finish_frame();
                end
            end
        end
        idle_on      = 1'b1;
        random_beats = beats_sent - start;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : test_sequence
        int waited;
        rst_n     <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= CFG_WIDTH;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        op        <= OP_PIXEL;
        chan0_in  <= '0;
        chan1_in  <= '0;
        chan2_in  <= '0;
        err_count      = 0;
        beats_sent     = 0;
        random_beats   = 0;
        pixels_checked = 0;
        frames_seen    = 0;
        settings_done  = 0;
        idle_on        = 1'b1;
        hold_req       = 0;
        model_reset();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_corner_pixels();
        test_channel_counts();
        test_geometry_limits();
        test_stalls();
        test_random_traffic();

        // drain what is still in flight, bounded
        in_valid <= 1'b0;
        waited = 0;
        while (pending_pixels.size() != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (IDLE_PAD) @(posedge clk);
        if (pending_pixels.size() != 0)
        begin
            $error("%0d predicted output pixels never came out", pending_pixels.size());
            err_count++;
        end

        $display("Covered %0d input beats (%0d random) and %0d output pixels in %0d frames,",
                 beats_sent, random_beats, pixels_checked, frames_seen);
        $display("over %0d register settings with zero sizes, all channel counts and stalls.",
                 settings_done);
        if (err_count == 0)
            $display("PASS conv3x3_rgb_zero_pad_clamp");
        else
            $display("FAIL conv3x3_rgb_zero_pad_clamp");
        $finish;
    end

    // ------------------------------------------------------------------
    // Output side: ready with random stalls per beat, plus long hold-off
    // ------------------------------------------------------------------
    initial
    begin : out_side
        int unsigned stall;
        out_ready <= 1'b0;
        stall = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_req != 0)
            begin
                stall    = hold_req;
                hold_req = 0;
            end
            else if (out_valid && out_ready)
                stall = idle_on ? $urandom_range(0, 9) : 0;
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                stall--;
            end
            else
                out_ready <= 1'b1;
        end
    end

    task automatic check_field(input string name, input logic [SAMPLE_W-1:0] want, got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            err_count++;
        end
    endtask

    // every output beat against the oldest predicted pixel
    always @(posedge clk)
    begin : result_check
        pix_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_pixels.size() == 0)
            begin
                $error("output beat with no pixel predicted");
                err_count++;
            end
            else
            begin
                want = pending_pixels.pop_front();
                check_field("chan0_out", want.chan0, chan0_out);
                check_field("chan1_out", want.chan1, chan1_out);
                check_field("chan2_out", want.chan2, chan2_out);
                check_field("alpha_out", want.alpha, alpha_out);
                check_field("frame_last", SAMPLE_W'(want.last), SAMPLE_W'(frame_last));
                pixels_checked++;
                if (want.last)
                    frames_seen++;
            end
        end
    end

    // hard stop well beyond the slowest legal run
    initial
    begin : watchdog
        #3_000_000;
        $display("FAIL conv3x3_rgb_zero_pad_clamp");
        $finish;
    end

endmodule
